[rtl/core/ctmc_pkg.sv]
// ----------------------------------------------------------------------------
// Circle tile map collision package
// Shared widths, register codes, reset values and the configuration struct.
// ----------------------------------------------------------------------------
package ctmc_pkg;

   localparam int GRID_DIM_DEF = 32;

   localparam int POS_W      = 16;
   localparam int QUO_W      = POS_W + 1;
   localparam int CELL_W     = 5;
   localparam int TILE_W     = 13;
   localparam int HALF_W     = TILE_W - 1;
   localparam int RAD_W      = 11;
   localparam int RAD2_W     = 2 * RAD_W;
   localparam int SQ_W       = RAD2_W + 1;
   localparam int DIM_CFG_W  = 6;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam int DIV_BITS   = 2;
   localparam int DIV_STEPS  = POS_W / DIV_BITS;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

   localparam logic [TILE_W-1:0]    TILE_SIZE_RST   = 13'd1280;
   localparam logic [RAD_W-1:0]     BODY_RADIUS_RST = 11'd51;
   localparam logic [DIM_CFG_W-1:0] ROWS_RST        = 6'd20;
   localparam logic [DIM_CFG_W-1:0] COLS_RST        = 6'd20;

   localparam logic [1:0] REG_TILE_SIZE   = 2'd0;
   localparam logic [1:0] REG_BODY_RADIUS = 2'd1;
   localparam logic [1:0] REG_ROWS        = 2'd2;
   localparam logic [1:0] REG_COLS        = 2'd3;

   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   localparam logic [1:0] NBR_LAST = 2'd2;

   typedef struct packed {
      logic [TILE_W-1:0]    tile_size;
      logic [RAD_W-1:0]     body_radius;
      logic [DIM_CFG_W-1:0] rows_in_use;
      logic [DIM_CFG_W-1:0] cols_in_use;
   } cfg_type;

endpackage

[rtl/core/ctmc_req_if.sv]
// ----------------------------------------------------------------------------
// Request channel interface
// Carries one map write or position query beat with valid and ready.
// ----------------------------------------------------------------------------
interface ctmc_req_if import ctmc_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic                    kind;
   logic [CELL_W-1:0]       cell_row;
   logic [CELL_W-1:0]       cell_col;
   logic                    wall_bit;
   logic signed [POS_W-1:0] pos_x;
   logic signed [POS_W-1:0] pos_z;

   modport source (output valid, kind, cell_row, cell_col, wall_bit, pos_x, pos_z,
                   input ready);
   modport sink (input valid, kind, cell_row, cell_col, wall_bit, pos_x, pos_z,
                 output ready);
endinterface

[rtl/core/ctmc_rsp_if.sv]
// ----------------------------------------------------------------------------
// Response channel interface
// Carries one collision result beat with valid and ready.
// ----------------------------------------------------------------------------
interface ctmc_rsp_if import ctmc_pkg::*; ();
   logic valid;
   logic ready;
   logic blocked;
   logic wall_touch;
   logic off_grid;

   modport source (output valid, blocked, wall_touch, off_grid, input ready);
   modport sink (input valid, blocked, wall_touch, off_grid, output ready);
endinterface

[rtl/core/circle_tile_map_collision_top.sv]
// ----------------------------------------------------------------------------
// Circle tile map collision top level
// Keeps a one-bit wall map and answers circle against wall queries.
// ----------------------------------------------------------------------------
// The request channel takes two kinds of beat. A write beat sets or clears
// one cell of the wall map and produces no response; it is a row read
// followed by a row write back into the map memory. A query beat carries
// a signed Q8.8 position and produces one response beat with blocked,
// wall_touch and off_grid.
// A query runs the two-bit-per-cycle divider that finds the cell and waits
// for it to finish, reads the neighboring cells one map row word at a
// time, drains the box test pipeline and then loads the response register.
// One request is in flight at a time; the next request is accepted once
// the response is loaded, even while the receiver still holds it off.
// After reset the map is cleared one row per cycle, while the request
// channel is held not ready. Registers sit behind the APB-style
// port and may be written at any time the block is idle.
// When the receiver stalls, the response stays in its register and a
// following query waits before its result is loaded.
// ----------------------------------------------------------------------------
module circle_tile_map_collision_top import ctmc_pkg::*; #(
   parameter int GRID_DIM = GRID_DIM_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   ctmc_req_if.sink              req_ch,
   ctmc_rsp_if.source            rsp_ch,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int IW   = $clog2(GRID_DIM);
   localparam int DIMW = $clog2(GRID_DIM + 1);
   localparam int RSW  = QUO_W + 1;

   typedef enum logic [6:0] {
      ST_CLEAR = 7'b0000001,
      ST_IDLE  = 7'b0000010,
      ST_WRITE = 7'b0000100,
      ST_DIV   = 7'b0001000,
      ST_SCAN  = 7'b0010000,
      ST_DRAIN = 7'b0100000,
      ST_OUT   = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   cfg_type             cfg;
   logic [TILE_W-1:0]   tile;
   logic [HALF_W-1:0]   half;
   logic [DIMW-1:0]     rows_eff;
   logic [DIMW-1:0]     cols_eff;

   logic signed [POS_W-1:0] pos_x_ff, pos_x_in;
   logic signed [POS_W-1:0] pos_z_ff, pos_z_in;
   logic [IW-1:0]       wr_row_ff, wr_row_in;
   logic [IW-1:0]       wr_col_ff, wr_col_in;
   logic                wr_bit_ff, wr_bit_in;
   logic [1:0]          dr_ff, dr_in;
   logic [1:0]          dc_ff, dc_in;
   logic                s1_v_ff, s1_v_in;
   logic [IW-1:0]       s1_r_ff, s1_r_in;
   logic [IW-1:0]       s1_c_ff, s1_c_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                blocked_ff, blocked_in;
   logic                touch_ff, touch_in;
   logic                off_ff, off_in;

   logic [IW-1:0]       mem_rd_addr;
   logic [GRID_DIM-1:0] mem_rd_data;
   logic                mem_wr_en;
   logic [GRID_DIM-1:0] mem_wr_data;
   logic                mem_clearing;

   logic                div_start;
   logic                div_busy;
   logic [QUO_W-1:0]    crow;
   logic [QUO_W-1:0]    ccol;

   logic                bt_clr;
   logic                bt_touch;
   logic                bt_busy;

   logic [RSW-1:0]      row_s;
   logic [RSW-1:0]      col_s;
   logic                cell_ok;
   logic                wr_in_range;
   logic                off_now;

   ctmc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   ctmc_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num_x (req_ch.pos_x),
      .num_z (req_ch.pos_z),
      .den   (tile),
      .busy  (div_busy),
      .quo_x (ccol),
      .quo_z (crow)
   );

   ctmc_map_mem #(
      .GRID_DIM (GRID_DIM)
   ) u_map_mem (
      .clock    (clock),
      .reset    (reset),
      .rd_addr  (mem_rd_addr),
      .rd_data  (mem_rd_data),
      .wr_en    (mem_wr_en),
      .wr_addr  (wr_row_ff),
      .wr_data  (mem_wr_data),
      .clearing (mem_clearing)
   );

   ctmc_box_test #(
      .GRID_DIM (GRID_DIM)
   ) u_box_test (
      .clock     (clock),
      .reset     (reset),
      .clr       (bt_clr),
      .cell_v    (s1_v_ff),
      .cell_wall (mem_rd_data[s1_c_ff]),
      .cell_row  (s1_r_ff),
      .cell_col  (s1_c_ff),
      .tile      (tile),
      .half      (half),
      .radius    (cfg.body_radius),
      .pos_x     (pos_x_ff),
      .pos_z     (pos_z_ff),
      .touch     (bt_touch),
      .busy      (bt_busy)
   );

   assign tile = (cfg.tile_size == '0) ? TILE_W'(1) : cfg.tile_size;
   assign half = tile[TILE_W-1:1];

   assign rows_eff = (32'(cfg.rows_in_use) > 32'(GRID_DIM)) ? DIMW'(GRID_DIM)
                                                             : DIMW'(cfg.rows_in_use);
   assign cols_eff = (32'(cfg.cols_in_use) > 32'(GRID_DIM)) ? DIMW'(GRID_DIM)
                                                             : DIMW'(cfg.cols_in_use);

   assign row_s = {crow[QUO_W-1], crow} + RSW'(dr_ff) - RSW'(1);
   assign col_s = {ccol[QUO_W-1], ccol} + RSW'(dc_ff) - RSW'(1);
   assign cell_ok = !row_s[RSW-1] && (row_s < RSW'(rows_eff)) &&
                    !col_s[RSW-1] && (col_s < RSW'(cols_eff));

   assign off_now = crow[QUO_W-1] || (crow >= QUO_W'(rows_eff)) ||
                    ccol[QUO_W-1] || (ccol >= QUO_W'(cols_eff));

   assign wr_in_range = (32'(req_ch.cell_row) < 32'(GRID_DIM)) &&
                        (32'(req_ch.cell_col) < 32'(GRID_DIM));

   assign req_ch.ready      = (state_ff == ST_IDLE);
   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.blocked    = blocked_ff;
   assign rsp_ch.wall_touch = touch_ff;
   assign rsp_ch.off_grid   = off_ff;

   always_comb begin
      state_in     = state_ff;
      pos_x_in     = pos_x_ff;
      pos_z_in     = pos_z_ff;
      wr_row_in    = wr_row_ff;
      wr_col_in    = wr_col_ff;
      wr_bit_in    = wr_bit_ff;
      dr_in        = dr_ff;
      dc_in        = dc_ff;
      s1_v_in      = 1'b0;
      s1_r_in      = s1_r_ff;
      s1_c_in      = s1_c_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      blocked_in   = blocked_ff;
      touch_in     = touch_ff;
      off_in       = off_ff;
      div_start    = 1'b0;
      bt_clr       = 1'b0;
      mem_wr_en    = 1'b0;
      mem_rd_addr  = IW'(req_ch.cell_row);
      mem_wr_data  = mem_rd_data;
      mem_wr_data[wr_col_ff] = wr_bit_ff;

      case (state_ff)
         ST_CLEAR: begin
            if (!mem_clearing) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_ch.valid) begin
               if (req_ch.kind == KIND_QUERY) begin
                  pos_x_in  = req_ch.pos_x;
                  pos_z_in  = req_ch.pos_z;
                  div_start = 1'b1;
                  state_in  = ST_DIV;
               end else if (wr_in_range) begin
                  wr_row_in = IW'(req_ch.cell_row);
                  wr_col_in = IW'(req_ch.cell_col);
                  wr_bit_in = req_ch.wall_bit;
                  state_in  = ST_WRITE;
               end
            end
         end
         ST_WRITE: begin
            mem_wr_en = 1'b1;
            state_in  = ST_IDLE;
         end
         ST_DIV: begin
            if (!div_busy) begin
               dr_in    = '0;
               dc_in    = '0;
               bt_clr   = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            mem_rd_addr = row_s[IW-1:0];
            s1_v_in     = cell_ok;
            s1_r_in     = row_s[IW-1:0];
            s1_c_in     = col_s[IW-1:0];
            if (dc_ff == NBR_LAST) begin
               dc_in = '0;
               if (dr_ff == NBR_LAST) begin
                  state_in = ST_DRAIN;
               end else begin
                  dr_in = dr_ff + 1'b1;
               end
            end else begin
               dc_in = dc_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            if (!s1_v_ff && !bt_busy) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               blocked_in   = bt_touch || off_now;
               touch_in     = bt_touch;
               off_in       = off_now;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         s1_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         s1_v_ff      <= s1_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_x_ff   <= pos_x_in;
      pos_z_ff   <= pos_z_in;
      wr_row_ff  <= wr_row_in;
      wr_col_ff  <= wr_col_in;
      wr_bit_ff  <= wr_bit_in;
      dr_ff      <= dr_in;
      dc_ff      <= dc_in;
      s1_r_ff    <= s1_r_in;
      s1_c_ff    <= s1_c_in;
      blocked_ff <= blocked_in;
      touch_ff   <= touch_in;
      off_ff     <= off_in;
   end

endmodule

[rtl/core/ctmc_csr.sv]
// ----------------------------------------------------------------------------
// Configuration registers
// APB-style register file holding tile size, radius and grid extent.
// ----------------------------------------------------------------------------
module ctmc_csr import ctmc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   cfg_type   cfg_ff;
   cfg_type   cfg_in;
   logic [1:0] reg_idx;

   assign reg_idx = paddr[CSR_ADDR_W-1:2];
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (psel && penable && pwrite) begin
         case (reg_idx)
            REG_TILE_SIZE:   cfg_in.tile_size   = pwdata[TILE_W-1:0];
            REG_BODY_RADIUS: cfg_in.body_radius = pwdata[RAD_W-1:0];
            REG_ROWS:        cfg_in.rows_in_use = pwdata[DIM_CFG_W-1:0];
            REG_COLS:        cfg_in.cols_in_use = pwdata[DIM_CFG_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_TILE_SIZE:   prdata = CSR_DATA_W'(cfg_ff.tile_size);
         REG_BODY_RADIUS: prdata = CSR_DATA_W'(cfg_ff.body_radius);
         REG_ROWS:        prdata = CSR_DATA_W'(cfg_ff.rows_in_use);
         REG_COLS:        prdata = CSR_DATA_W'(cfg_ff.cols_in_use);
         default:         prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tile_size   <= TILE_SIZE_RST;
         cfg_ff.body_radius <= BODY_RADIUS_RST;
         cfg_ff.rows_in_use <= ROWS_RST;
         cfg_ff.cols_in_use <= COLS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[rtl/core/ctmc_div.sv]
// ----------------------------------------------------------------------------
// Cell index divider
// Two-lane restoring divider, two quotient bits per cycle, truncating to zero.
// ----------------------------------------------------------------------------
module ctmc_div import ctmc_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [POS_W-1:0] num_x,
   input  logic signed [POS_W-1:0] num_z,
   input  logic [TILE_W-1:0]       den,
   output logic                    busy,
   output logic [QUO_W-1:0]        quo_x,
   output logic [QUO_W-1:0]        quo_z
);

   logic                 busy_ff, busy_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [TILE_W-1:0]    rem_ff [2];
   logic [TILE_W-1:0]    rem_in [2];
   logic [POS_W-1:0]     quo_ff [2];
   logic [POS_W-1:0]     quo_in [2];
   logic                 neg_ff [2];
   logic                 neg_in [2];
   logic [QUO_W-1:0]     res [2];
   logic [TILE_W-1:0]    r;
   logic [POS_W-1:0]     q;
   logic [TILE_W:0]      t;
   logic [POS_W-1:0]     num [2];

   assign num[0] = num_x;
   assign num[1] = num_z;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      r = '0;
      q = '0;
      t = '0;
      for (int l = 0; l < 2; l++) begin
         rem_in[l] = rem_ff[l];
         quo_in[l] = quo_ff[l];
         neg_in[l] = neg_ff[l];
      end
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         for (int l = 0; l < 2; l++) begin
            rem_in[l] = '0;
            neg_in[l] = num[l][POS_W-1];
            quo_in[l] = num[l][POS_W-1] ? (POS_W'(0) - num[l]) : num[l];
         end
      end else if (busy_ff) begin
         for (int l = 0; l < 2; l++) begin
            r = rem_ff[l];
            q = quo_ff[l];
            for (int b = 0; b < DIV_BITS; b++) begin
               t = {r, q[POS_W-1]};
               q = {q[POS_W-2:0], 1'b0};
               if (t >= {1'b0, den}) begin
                  t    = t - {1'b0, den};
                  q[0] = 1'b1;
               end
               r = t[TILE_W-1:0];
            end
            rem_in[l] = r;
            quo_in[l] = q;
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         res[l] = neg_ff[l] ? (QUO_W'(0) - {1'b0, quo_ff[l]}) : {1'b0, quo_ff[l]};
      end
   end

   assign busy  = busy_ff;
   assign quo_x = res[0];
   assign quo_z = res[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int l = 0; l < 2; l++) begin
         rem_ff[l] <= rem_in[l];
         quo_ff[l] <= quo_in[l];
         neg_ff[l] <= neg_in[l];
      end
   end

endmodule

[rtl/core/ctmc_map_mem.sv]
// ----------------------------------------------------------------------------
// Wall map memory
// One map row per word, registered read, with a row-by-row clear after reset.
// ----------------------------------------------------------------------------
module ctmc_map_mem import ctmc_pkg::*; #(
   parameter int GRID_DIM = GRID_DIM_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [$clog2(GRID_DIM)-1:0]   rd_addr,
   output logic [GRID_DIM-1:0]           rd_data,
   input  logic                          wr_en,
   input  logic [$clog2(GRID_DIM)-1:0]   wr_addr,
   input  logic [GRID_DIM-1:0]           wr_data,
   output logic                          clearing
);

   localparam int IW = $clog2(GRID_DIM);

   logic [GRID_DIM-1:0] mem [GRID_DIM];
   logic [GRID_DIM-1:0] rd_data_ff;
   logic                clearing_ff, clearing_in;
   logic [IW-1:0]       clr_cnt_ff, clr_cnt_in;

   assign rd_data  = rd_data_ff;
   assign clearing = clearing_ff;

   always_comb begin
      clearing_in = clearing_ff;
      clr_cnt_in  = clr_cnt_ff;
      if (clearing_ff) begin
         clr_cnt_in = clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == IW'(GRID_DIM - 1)) begin
            clearing_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_cnt_ff  <= '0;
      end else begin
         clearing_ff <= clearing_in;
         clr_cnt_ff  <= clr_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         mem[clr_cnt_ff] <= '0;
      end else if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

endmodule

[rtl/core/ctmc_box_test.sv]
// ----------------------------------------------------------------------------
// Wall box test pipeline
// Three-stage circle against square box test with a sticky touch flag.
// ----------------------------------------------------------------------------
module ctmc_box_test import ctmc_pkg::*; #(
   parameter int GRID_DIM = GRID_DIM_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          clr,
   input  logic                          cell_v,
   input  logic                          cell_wall,
   input  logic [$clog2(GRID_DIM)-1:0]   cell_row,
   input  logic [$clog2(GRID_DIM)-1:0]   cell_col,
   input  logic [TILE_W-1:0]             tile,
   input  logic [HALF_W-1:0]             half,
   input  logic [RAD_W-1:0]              radius,
   input  logic signed [POS_W-1:0]       pos_x,
   input  logic signed [POS_W-1:0]       pos_z,
   output logic                          touch,
   output logic                          busy
);

   localparam int IW  = $clog2(GRID_DIM);
   localparam int CXW = IW + TILE_W;
   localparam int SW  = CXW + 2;

   function automatic logic [RAD_W-1:0] gap_mag(input logic signed [SW-1:0] p,
                                                input logic signed [SW-1:0] c,
                                                input logic signed [SW-1:0] h);
      logic signed [SW-1:0] lo;
      logic signed [SW-1:0] hi;
      logic [SW-1:0]        d;
      lo = c - h;
      hi = c + h;
      if (p < lo) begin
         d = lo - p;
      end else if (p > hi) begin
         d = p - hi;
      end else begin
         d = '0;
      end
      if (d > SW'({RAD_W{1'b1}})) begin
         return {RAD_W{1'b1}};
      end
      return d[RAD_W-1:0];
   endfunction

   logic              b_live_ff, b_live_in;
   logic [CXW-1:0]    b_cx_ff, b_cx_in;
   logic [CXW-1:0]    b_cz_ff, b_cz_in;
   logic              c_live_ff, c_live_in;
   logic [RAD_W-1:0]  c_dx_ff, c_dx_in;
   logic [RAD_W-1:0]  c_dz_ff, c_dz_in;
   logic              touch_ff, touch_in;
   logic [RAD2_W-1:0] rad2_ff, rad2_in;
   logic signed [SW-1:0] px_w, pz_w, cx_w, cz_w, h_w;
   logic [SQ_W-1:0]   sq_sum;

   assign px_w = {{(SW-POS_W){pos_x[POS_W-1]}}, pos_x};
   assign pz_w = {{(SW-POS_W){pos_z[POS_W-1]}}, pos_z};
   assign cx_w = {2'b00, b_cx_ff};
   assign cz_w = {2'b00, b_cz_ff};
   assign h_w  = SW'(half);

   assign sq_sum = SQ_W'(c_dx_ff) * SQ_W'(c_dx_ff) + SQ_W'(c_dz_ff) * SQ_W'(c_dz_ff);

   always_comb begin
      b_live_in = cell_v && cell_wall;
      b_cx_in   = CXW'(cell_col) * CXW'(tile);
      b_cz_in   = CXW'(cell_row) * CXW'(tile);
      c_live_in = b_live_ff;
      c_dx_in   = gap_mag(px_w, cx_w, h_w);
      c_dz_in   = gap_mag(pz_w, cz_w, h_w);
      rad2_in   = rad2_ff;
      touch_in  = touch_ff;
      if (clr) begin
         touch_in = 1'b0;
         rad2_in  = RAD2_W'(radius) * RAD2_W'(radius);
      end else if (c_live_ff && (sq_sum < SQ_W'(rad2_ff))) begin
         touch_in = 1'b1;
      end
   end

   assign touch = touch_ff;
   assign busy  = b_live_ff || c_live_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_live_ff <= 1'b0;
         c_live_ff <= 1'b0;
         touch_ff  <= 1'b0;
      end else begin
         b_live_ff <= b_live_in;
         c_live_ff <= c_live_in;
         touch_ff  <= touch_in;
      end
   end

   always_ff @(posedge clock) begin
      b_cx_ff <= b_cx_in;
      b_cz_ff <= b_cz_in;
      c_dx_ff <= c_dx_in;
      c_dz_ff <= c_dz_in;
      rad2_ff <= rad2_in;
   end

endmodule

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// Circle tile map collision testbench
// Drives map writes and position queries into the block, keeps its own model
// of the wall map and the registers, and checks every response beat in order
// against the predicted blocked, wall_touch and off_grid flags. Register
// settings change between phases, while the block is idle, and both channels
// idle and stall at random.
// ----------------------------------------------------------------------------
module tb import ctmc_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 400000;
   localparam int LONG_HOLD   = 300;
   localparam int SETTLE      = 32;

   typedef struct packed {
      logic blocked;
      logic wall_touch;
      logic off_grid;
   } verdict_type;

   typedef struct packed {
      logic                    kind;
      logic [CELL_W-1:0]       row;
      logic [CELL_W-1:0]       col;
      logic                    wall;
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_z;
   } map_beat_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   ctmc_req_if req_if ();
   ctmc_rsp_if rsp_if ();

   circle_tile_map_collision_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_if),
      .rsp_ch      (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   bit          wall_map [0:GRID_DIM_DEF*GRID_DIM_DEF-1];
   cfg_type     cfg_shadow;
   verdict_type pending_results [$];
   int          error_count   = 0;
   int          cycle_count   = 0;
   int          burst_left    = 0;
   bit          steady_send   = 0;
   int          hold_requests = 0;
   int          hold_served   = 0;

   initial begin
      clock = 1'b0;
   end

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   function automatic verdict_type compute_verdict(logic signed [POS_W-1:0] qx,
                                                   logic signed [POS_W-1:0] qz);
      int          px, pz, tile, half, rows, cols, crow, ccol;
      longint      rad2, lo, hi, nx, nz, dx, dz;
      logic        touch;
      verdict_type v;
      px   = qx;
      pz   = qz;
      tile = (cfg_shadow.tile_size == 0) ? 1 : int'(cfg_shadow.tile_size);
      half = tile / 2;
      rows = (cfg_shadow.rows_in_use > GRID_DIM_DEF) ? GRID_DIM_DEF
                                                     : int'(cfg_shadow.rows_in_use);
      cols = (cfg_shadow.cols_in_use > GRID_DIM_DEF) ? GRID_DIM_DEF
                                                     : int'(cfg_shadow.cols_in_use);
      crow = pz / tile;
      ccol = px / tile;
      rad2 = longint'(cfg_shadow.body_radius) * longint'(cfg_shadow.body_radius);
      touch = 1'b0;
      for (int r = crow - 1; r <= crow + 1; r++) begin
         for (int c = ccol - 1; c <= ccol + 1; c++) begin
            if (r >= 0 && r < rows && c >= 0 && c < cols &&
                wall_map[r * GRID_DIM_DEF + c]) begin
               lo = longint'(c) * tile - half;
               hi = longint'(c) * tile + half;
               nx = (px < lo) ? lo : ((px > hi) ? hi : px);
               lo = longint'(r) * tile - half;
               hi = longint'(r) * tile + half;
               nz = (pz < lo) ? lo : ((pz > hi) ? hi : pz);
               dx = px - nx;
               dz = pz - nz;
               if (dx * dx + dz * dz < rad2) touch = 1'b1;
            end
         end
      end
      v.off_grid   = (crow < 0 || crow >= rows || ccol < 0 || ccol >= cols);
      v.wall_touch = touch;
      v.blocked    = touch | v.off_grid;
      return v;
   endfunction

   function automatic int near_coord(int tile, int dim);
      int tile_idx, v;
      tile_idx = int'($urandom_range(0, dim + 1)) - 1;
      v = tile_idx * tile + int'($urandom_range(0, 2 * tile)) - tile;
      if (v < -32768) v = -32768;
      if (v > 32767) v = 32767;
      return v;
   endfunction

   function automatic int pick_dim();
      case ($urandom_range(0, 19))
         0: return 1;
         1: return 32;
         2: return 0;
         3: return 63;
         default: return $urandom_range(2, 32);
      endcase
   endfunction

   task automatic send_beat(map_beat_type b);
      int gap;
      if (!steady_send && burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         burst_left = $urandom_range(1, 12);
         repeat (gap) begin
            @(negedge clock);
            req_if.valid <= 1'b0;
         end
      end
      if (burst_left > 0) burst_left--;
      @(negedge clock);
      req_if.valid    <= 1'b1;
      req_if.kind     <= b.kind;
      req_if.cell_row <= b.row;
      req_if.cell_col <= b.col;
      req_if.wall_bit <= b.wall;
      req_if.pos_x    <= b.pos_x;
      req_if.pos_z    <= b.pos_z;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      if (b.kind == KIND_WRITE) begin
         wall_map[{b.row, b.col}] = b.wall;
      end else begin
         pending_results.insert(pending_results.size(),
                                compute_verdict(b.pos_x, b.pos_z));
      end
   endtask

   task automatic send_wall(int row, int col, bit wall);
      map_beat_type b;
      b = '0;
      b.kind = KIND_WRITE;
      b.row  = row[CELL_W-1:0];
      b.col  = col[CELL_W-1:0];
      b.wall = wall;
      b.pos_x = POS_W'($urandom);
      b.pos_z = POS_W'($urandom);
      send_beat(b);
   endtask

   task automatic send_query(int x, int z);
      map_beat_type b;
      b = '0;
      b.kind  = KIND_QUERY;
      b.row   = CELL_W'($urandom);
      b.col   = CELL_W'($urandom);
      b.wall  = 1'($urandom);
      b.pos_x = x[POS_W-1:0];
      b.pos_z = z[POS_W-1:0];
      send_beat(b);
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] code, int value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {code, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      case (code)
         REG_TILE_SIZE:   cfg_shadow.tile_size   = value[TILE_W-1:0];
         REG_BODY_RADIUS: cfg_shadow.body_radius = value[RAD_W-1:0];
         REG_ROWS:        cfg_shadow.rows_in_use = value[DIM_CFG_W-1:0];
         default:         cfg_shadow.cols_in_use = value[DIM_CFG_W-1:0];
      endcase
   endtask

   task automatic set_config(int tile, int radius, int rows, int cols);
      wait_idle();
      csr_write(REG_TILE_SIZE, tile);
      csr_write(REG_BODY_RADIUS, radius);
      csr_write(REG_ROWS, rows);
      csr_write(REG_COLS, cols);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic test_empty_map();
      send_query(0, 0);
      send_query(-1, -1);
      send_query(-1280, 0);
      send_query(0, -1280);
      send_query(32767, 32767);
      send_query(-32768, -32768);
   endtask

   task automatic test_wall_boxes();
      send_wall(2, 3, 1'b1);
      send_wall(31, 31, 1'b1);
      send_wall(0, 0, 1'b1);
      send_query(3 * 1280 + 640 + 30, 2 * 1280);
      send_query(3 * 1280 + 640 + 51, 2 * 1280);
      send_query(3 * 1280, 2 * 1280);
      send_query(-50, 0);
      send_wall(2, 3, 1'b0);
      send_query(3 * 1280, 2 * 1280);
   endtask

   task automatic test_register_corners();
      set_config(0, 2047, 63, 63);
      send_query(31, 31);
      send_query(40, 40);
      send_query(32, 32);
      set_config(1280, 1280, 20, 20);
      send_query(-1300, 0);
      set_config(8191, 0, 0, 0);
      send_query(0, 0);
      set_config(8191, 0, 32, 32);
      send_query(0, 0);
      set_config(256, 1, 1, 1);
      send_query(0, 0);
      send_query(256, 0);
      set_config(TILE_SIZE_RST, BODY_RADIUS_RST, ROWS_RST, COLS_RST);
   endtask

   task automatic test_backpressure();
      steady_send = 1'b1;
      hold_requests++;
      for (int n = 0; n < 16; n++) send_query(near_coord(1280, 20), near_coord(1280, 20));
      steady_send = 1'b0;
      wait_idle();
   endtask

   task automatic test_random_traffic();
      int tile, radius, rows, cols;
      for (int phase = 0; phase < 8; phase++) begin
         case ($urandom_range(0, 9))
            0: tile = 256;
            1: tile = 8191;
            2: tile = 0;
            3: tile = $urandom_range(0, 8191);
            default: tile = $urandom_range(256, 1536);
         endcase
         case ($urandom_range(0, 9))
            0: radius = 0;
            1: radius = 1280;
            2: radius = 2047;
            default: radius = $urandom_range(1, 1280);
         endcase
         set_config(tile, radius, pick_dim(), pick_dim());
         if (phase == 5) hold_requests++;
         steady_send = ($urandom_range(0, 3) == 0);
         tile = (tile == 0) ? 1 : tile;
         rows = (cfg_shadow.rows_in_use > GRID_DIM_DEF) ? GRID_DIM_DEF
                                                        : int'(cfg_shadow.rows_in_use);
         cols = (cfg_shadow.cols_in_use > GRID_DIM_DEF) ? GRID_DIM_DEF
                                                        : int'(cfg_shadow.cols_in_use);
         for (int n = 0; n < 75; n++) begin
            if ($urandom_range(0, 9) < 3) begin
               send_wall($urandom_range(0, 31), $urandom_range(0, 31),
                         $urandom_range(0, 99) < 65);
            end else if ($urandom_range(0, 4) == 0) begin
               send_query($urandom, $urandom);
            end else begin
               send_query(near_coord(tile, cols), near_coord(tile, rows));
            end
         end
      end
      steady_send = 1'b0;
   endtask

   initial begin
      int mode, mode_left, stall_left, hold_left;
      mode       = 0;
      mode_left  = 0;
      stall_left = 0;
      hold_left  = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_served < hold_requests) begin
            hold_served++;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode      = $urandom_range(0, 3);
               mode_left = $urandom_range(20, 150);
            end
            mode_left--;
            case (mode)
               0: rsp_if.ready <= 1'b1;
               1: rsp_if.ready <= 1'($urandom_range(0, 1));
               2: rsp_if.ready <= ($urandom_range(0, 9) != 0);
               default: begin
                  if (stall_left == 0 && $urandom_range(0, 7) == 0)
                     stall_left = $urandom_range(1, 15);
                  if (stall_left > 0) begin
                     stall_left--;
                     rsp_if.ready <= 1'b0;
                  end else begin
                     rsp_if.ready <= 1'b1;
                  end
               end
            endcase
         end
      end
   end

   always @(posedge clock) begin : check_results
      verdict_type want;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         if (pending_results.size() == 0) begin
            $error("response beat with no query waiting");
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_if.blocked !== want.blocked) begin
               $error("blocked: expected %0b, actual %0b", want.blocked, rsp_if.blocked);
               error_count++;
            end
            if (rsp_if.wall_touch !== want.wall_touch) begin
               $error("wall_touch: expected %0b, actual %0b",
                      want.wall_touch, rsp_if.wall_touch);
               error_count++;
            end
            if (rsp_if.off_grid !== want.off_grid) begin
               $error("off_grid: expected %0b, actual %0b", want.off_grid, rsp_if.off_grid);
               error_count++;
            end
         end
      end
   end

   initial begin
      reset           = 1'b1;
      req_if.valid    = 1'b0;
      req_if.kind     = KIND_WRITE;
      req_if.cell_row = '0;
      req_if.cell_col = '0;
      req_if.wall_bit = 1'b0;
      req_if.pos_x    = '0;
      req_if.pos_z    = '0;
      csr_psel        = 1'b0;
      csr_penable     = 1'b0;
      csr_pwrite      = 1'b0;
      csr_paddr       = '0;
      csr_pwdata      = '0;
      cfg_shadow.tile_size   = TILE_SIZE_RST;
      cfg_shadow.body_radius = BODY_RADIUS_RST;
      cfg_shadow.rows_in_use = ROWS_RST;
      cfg_shadow.cols_in_use = COLS_RST;
      foreach (wall_map[i]) wall_map[i] = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_empty_map();
      test_wall_boxes();
      test_register_corners();
      test_backpressure();
      test_random_traffic();
      wait_idle();
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/core/ctmc_pkg.sv
rtl/core/ctmc_req_if.sv
rtl/core/ctmc_rsp_if.sv
rtl/core/ctmc_csr.sv
rtl/core/ctmc_div.sv
rtl/core/ctmc_map_mem.sv
rtl/core/ctmc_box_test.sv
rtl/core/circle_tile_map_collision_top.sv
tb/sv/tb.sv
